FILE: rtl/lgovl_pkg.sv
// Shared types and constants for the logo overlay block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package lgovl_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WINDOW_START    = 3'd0,
    REG_WINDOW_LENGTH   = 3'd1,
    REG_WHITE_SUM_LIMIT = 3'd2,
    REG_BLACK_SUM_LIMIT = 3'd3
  } reg_index_t;

  // Register reset values
  localparam logic [9:0] WINDOW_START_RST    = 10'd259;
  localparam logic [9:0] WINDOW_LENGTH_RST   = 10'd236;
  localparam logic [9:0] WHITE_SUM_LIMIT_RST = 10'd747;
  localparam logic [9:0] BLACK_SUM_LIMIT_RST = 10'd10;

  // Forced grey levels, quarter units (242.25 * 4 and 67 * 4)
  localparam logic [9:0] GREY_WHITE4 = 10'd969;
  localparam logic [9:0] GREY_BLACK4 = 10'd268;

  // Transparency key: pure red
  localparam logic [7:0] KEY_RED   = 8'hFF;
  localparam logic [7:0] KEY_GREEN = 8'h00;
  localparam logic [7:0] KEY_BLUE  = 8'h00;

  typedef struct packed {
    logic [9:0] window_start;
    logic [9:0] window_length;
    logic [9:0] white_sum_limit;
    logic [9:0] black_sum_limit;
  } cfg_t;

  // One beat leaving the conditioning stages
  typedef struct packed {
    logic       valid;
    logic       use_logo;
    logic [9:0] luma;
    logic [9:0] cb;
    logic [9:0] cr;
    logic [9:0] r4;
    logic [9:0] g4;
    logic [9:0] b4;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/lgovl_regs.sv
// Configuration register file for the logo overlay block.
// Depends on lgovl_pkg.
`default_nettype none

module lgovl_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [9:0]        cfg_data,
  output lgovl_pkg::cfg_t        cfg
);

  // Writes land on the clock edge; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start    <= lgovl_pkg::WINDOW_START_RST;
      cfg.window_length   <= lgovl_pkg::WINDOW_LENGTH_RST;
      cfg.white_sum_limit <= lgovl_pkg::WHITE_SUM_LIMIT_RST;
      cfg.black_sum_limit <= lgovl_pkg::BLACK_SUM_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lgovl_pkg::REG_WINDOW_START:    cfg.window_start    <= cfg_data;
        lgovl_pkg::REG_WINDOW_LENGTH:   cfg.window_length   <= cfg_data;
        lgovl_pkg::REG_WHITE_SUM_LIMIT: cfg.white_sum_limit <= cfg_data;
        lgovl_pkg::REG_BLACK_SUM_LIMIT: cfg.black_sum_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lgovl_cond.sv
// Window/key decision and logo pixel conditioning, two pipeline stages.
// Depends on lgovl_pkg.
`default_nettype none

module lgovl_cond #(
  parameter int unsigned LINE_SAMPLES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [9:0]        column,
  input  wire logic [9:0]        video_luma,
  input  wire logic [9:0]        video_cb,
  input  wire logic [9:0]        video_cr,
  input  wire logic [7:0]        logo_red,
  input  wire logic [7:0]        logo_green,
  input  wire logic [7:0]        logo_blue,
  input  wire lgovl_pkg::cfg_t   cfg,
  output lgovl_pkg::item_t       item
);

  logic        in_window;
  logic        key;
  logic [10:0] window_end;

  logic        v1;
  logic        use1;
  logic [9:0]  sum1;
  logic [9:0]  luma1, cb1, cr1;
  logic [7:0]  red1, green1, blue1;

  logic        white;
  logic        black;

  // Stage 1: window test, key test, RGB sum
  assign window_end = {1'b0, cfg.window_start} + {1'b0, cfg.window_length};
  assign in_window = (column >= cfg.window_start) &&
                     ({1'b0, column} < window_end) &&
                     (32'(column) < LINE_SAMPLES);
  assign key = (logo_red == lgovl_pkg::KEY_RED) &&
               (logo_green == lgovl_pkg::KEY_GREEN) &&
               (logo_blue == lgovl_pkg::KEY_BLUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    use1   <= in_window && !key;
    sum1   <= 10'(logo_red) + 10'(logo_green) + 10'(logo_blue);
    luma1  <= video_luma;
    cb1    <= video_cb;
    cr1    <= video_cr;
    red1   <= logo_red;
    green1 <= logo_green;
    blue1  <= logo_blue;
  end

  // Stage 2: force near-white / near-black to grey, black wins
  assign white = sum1 > cfg.white_sum_limit;
  assign black = sum1 < cfg.black_sum_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= v1;
    end
    item.use_logo <= use1;
    item.luma     <= luma1;
    item.cb       <= cb1;
    item.cr       <= cr1;
    priority if (black) begin
      item.r4 <= lgovl_pkg::GREY_BLACK4;
      item.g4 <= lgovl_pkg::GREY_BLACK4;
      item.b4 <= lgovl_pkg::GREY_BLACK4;
    end else if (white) begin
      item.r4 <= lgovl_pkg::GREY_WHITE4;
      item.g4 <= lgovl_pkg::GREY_WHITE4;
      item.b4 <= lgovl_pkg::GREY_WHITE4;
    end else begin
      item.r4 <= {red1, 2'b00};
      item.g4 <= {green1, 2'b00};
      item.b4 <= {blue1, 2'b00};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lgovl_csc.sv
// RGB to 10-bit studio YCbCr conversion and output select, five stages.
// Depends on lgovl_pkg; coefficients are derived from FRACTION_BITS.
`default_nettype none

module lgovl_csc #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lgovl_pkg::item_t  item,
  output logic                   strobe,
  output logic [9:0]             out_luma,
  output logic [9:0]             out_cb,
  output logic [9:0]             out_cr,
  output logic                   logo_used
);

  localparam longint unsigned OneF = 64'd1 << FRACTION_BITS;
  localparam int unsigned KwW      = FRACTION_BITS + 2;
  localparam int unsigned ProdW    = FRACTION_BITS + 10;
  localparam int unsigned YqW      = FRACTION_BITS + 11;
  localparam int unsigned DW       = FRACTION_BITS + 12;
  localparam int unsigned PyW      = YqW + KwW;
  localparam int unsigned PcW      = DW + KwW + 1;
  localparam int unsigned AccW     = PcW + 1;
  localparam int unsigned OutShift = 2 * FRACTION_BITS + 2;
  localparam int unsigned HiW      = AccW - OutShift;
  localparam int unsigned LumW     = PyW - OutShift;

  localparam logic [KwW-1:0] Kr  = KwW'((299 * OneF + 500) / 1000);
  localparam logic [KwW-1:0] Kg  = KwW'((587 * OneF + 500) / 1000);
  localparam logic [KwW-1:0] Kb  = KwW'((114 * OneF + 500) / 1000);
  localparam logic [KwW-1:0] Kys = KwW'((876 * OneF + 127) / 255);
  localparam logic [KwW-1:0] Ku  =
    KwW'((64'd5643371 * 7 * OneF + 64'd10000000) / 64'd20000000);
  localparam logic [KwW-1:0] Kv  =
    KwW'((64'd7132641 * 7 * OneF + 64'd10000000) / 64'd20000000);
  localparam logic signed [PcW-1:0]  KuS  = PcW'(Ku);
  localparam logic signed [PcW-1:0]  KvS  = PcW'(Kv);
  localparam logic signed [AccW-1:0] Bias = AccW'(512) <<< OutShift;

  // A negative result is treated like a huge unsigned value,
  // so both directions of overflow clamp to full scale
  function automatic logic [9:0] chroma_sat(input logic signed [HiW-1:0] hi);
    logic [9:0] res;
    if (hi[HiW-1] || (hi > HiW'(1023))) begin
      res = 10'd1023;
    end else begin
      res = hi[9:0];
    end
    return res;
  endfunction

  logic [4:0] vld;  // valid bits for stages 3 through 7

  // Stage 3 regs
  logic [ProdW-1:0] p_r, p_g, p_b;
  logic [9:0]       r4_3, b4_3, luma3, cb3, cr3;
  logic             use3;
  // Stage 4 regs
  logic [YqW-1:0]   yq4;
  logic [9:0]       r4_4, b4_4, luma4, cb4, cr4;
  logic             use4;
  // Stage 5 regs
  logic [YqW-1:0]        yq5;
  logic signed [DW-1:0]  d_b, d_r;
  logic [9:0]            luma5, cb5, cr5;
  logic                  use5;
  // Stage 6 regs
  logic [PyW-1:0]        prod_y;
  logic signed [PcW-1:0] prod_b, prod_r;
  logic [9:0]            luma6, cb6, cr6;
  logic                  use6;

  // Final stage combinational terms
  logic signed [AccW-1:0] acc_b, acc_r;
  logic [LumW:0]          lum;

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], item.valid};
    end
  end

  // Stage 3: the three weighted products
  always_ff @(posedge clk) begin
    p_r   <= ProdW'(item.r4) * ProdW'(Kr);
    p_g   <= ProdW'(item.g4) * ProdW'(Kg);
    p_b   <= ProdW'(item.b4) * ProdW'(Kb);
    r4_3  <= item.r4;
    b4_3  <= item.b4;
    luma3 <= item.luma;
    cb3   <= item.cb;
    cr3   <= item.cr;
    use3  <= item.use_logo;
  end

  // Stage 4: luma sum
  always_ff @(posedge clk) begin
    yq4   <= YqW'(p_r) + YqW'(p_g) + YqW'(p_b);
    r4_4  <= r4_3;
    b4_4  <= b4_3;
    luma4 <= luma3;
    cb4   <= cb3;
    cr4   <= cr3;
    use4  <= use3;
  end

  // Stage 5: color differences B-Y and R-Y
  always_ff @(posedge clk) begin
    yq5   <= yq4;
    d_b   <= $signed(DW'(b4_4) << FRACTION_BITS) - $signed(DW'(yq4));
    d_r   <= $signed(DW'(r4_4) << FRACTION_BITS) - $signed(DW'(yq4));
    luma5 <= luma4;
    cb5   <= cb4;
    cr5   <= cr4;
    use5  <= use4;
  end

  // Stage 6: output scaling multiplies
  always_ff @(posedge clk) begin
    prod_y <= PyW'(yq5) * PyW'(Kys);
    prod_b <= PcW'(d_b) * KuS;
    prod_r <= PcW'(d_r) * KvS;
    luma6  <= luma5;
    cb6    <= cb5;
    cr6    <= cr5;
    use6   <= use5;
  end

  // Stage 7: offsets, truncation, saturation and select
  assign acc_b = AccW'(prod_b) + Bias;
  assign acc_r = AccW'(prod_r) + Bias;
  assign lum   = (LumW + 1)'(prod_y[PyW-1:OutShift]) + (LumW + 1)'(64);

  always_ff @(posedge clk) begin
    logo_used <= use6;
    if (use6) begin
      out_luma <= (lum > (LumW + 1)'(1023)) ? 10'd1023 : lum[9:0];
      out_cb   <= chroma_sat(acc_b[AccW-1:OutShift]);
      out_cr   <= chroma_sat(acc_r[AccW-1:OutShift]);
    end else begin
      out_luma <= luma6;
      out_cb   <= cb6;
      out_cr   <= cr6;
    end
  end

  assign strobe = vld[4];

endmodule

`default_nettype wire

FILE: rtl/logo_rgb_to_ycbcr_keyed_overlay_unit.sv
// Logo overlay: an accepted start reaches its strobe through the lgovl_cond and lgovl_csc stages.
// Throughput is one sample per clock; busy never rises, so start may be held
// high every cycle. Each of the seven register stages takes a new beat per clock.
// Results cannot be stalled by the receiver. Synchronous reset clears all
// valid bits and loads the registers with their default window and limits.
// Depends on lgovl_pkg, lgovl_regs, lgovl_cond, lgovl_csc.
`default_nettype none

module logo_rgb_to_ycbcr_keyed_overlay_unit #(
  parameter int unsigned LINE_SAMPLES  = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command side
  input  wire logic        start,
  output logic             busy,
  input  wire logic [9:0]  column,
  input  wire logic [9:0]  video_luma,
  input  wire logic [9:0]  video_cb,
  input  wire logic [9:0]  video_cr,
  input  wire logic [7:0]  logo_red,
  input  wire logic [7:0]  logo_green,
  input  wire logic [7:0]  logo_blue,
  // result side
  output logic             strobe,
  output logic [9:0]       out_luma,
  output logic [9:0]       out_cb,
  output logic [9:0]       out_cr,
  output logic             logo_used,
  // register write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  lgovl_pkg::cfg_t  cfg;
  lgovl_pkg::item_t item;
  logic             accept;

  // Fully pipelined: always ready for a beat and for a register write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  lgovl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lgovl_cond #(
    .LINE_SAMPLES (LINE_SAMPLES)
  ) u_cond (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .column     (column),
    .video_luma (video_luma),
    .video_cb   (video_cb),
    .video_cr   (video_cr),
    .logo_red   (logo_red),
    .logo_green (logo_green),
    .logo_blue  (logo_blue),
    .cfg        (cfg),
    .item       (item)
  );

  lgovl_csc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_csc (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .strobe    (strobe),
    .out_luma  (out_luma),
    .out_cb    (out_cb),
    .out_cr    (out_cr),
    .logo_used (logo_used)
  );

  // Every result beat traces back to an accepted start
  a_strobe_has_start: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, 7))
    else $error("result beat without a matching start");

  // Pass-through beats carry the video sample unchanged
  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    (strobe && !logo_used) |->
      (out_luma == $past(video_luma, 7)) && (out_cb == $past(video_cb, 7)) &&
      (out_cr == $past(video_cr, 7)))
    else $error("pass-through beat altered the video sample");

  // Logo only replaces video at or after the window start
  a_logo_in_window: assert property (@(posedge clk) disable iff (rst)
    (strobe && logo_used) |-> ($past(column, 7) >= $past(cfg.window_start, 7)))
    else $error("logo used before the window start");

  // A write to the window start register takes effect on the next edge
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == lgovl_pkg::REG_WINDOW_START)) |=>
      (cfg.window_start == $past(cfg_data)))
    else $error("window start write lost");

endmodule

`default_nettype wire
